@@ rtl/assert_macros.svh @@
// Assertion helpers included by the camera core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/fcb_pkg.sv @@
package fcb_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int ITER_W = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [25:0] PITCH_LIMIT = 26'sd16202;
	localparam logic signed [15:0] UNIT_ONE = 16'sd16384;
	localparam int ROOT_STEPS = 32;
	localparam int DIV_BITS = 15;

	localparam logic [1:0] OP_MOVE = 2'd0;
	localparam logic [1:0] OP_TURN = 2'd1;
	localparam logic [1:0] OP_PLACE = 2'd2;

	localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
	localparam logic [2:0] REG_TURN_SPEED = 3'd1;
	localparam logic [2:0] REG_WUP_X = 3'd2;
	localparam logic [2:0] REG_WUP_Y = 3'd3;
	localparam logic [2:0] REG_WUP_Z = 3'd4;
	localparam logic [2:0] REG_START_YAW = 3'd5;
	localparam logic [2:0] REG_START_PITCH = 3'd6;

	typedef struct packed {
		logic start;
		logic div_mode;
	} rd_req_t;

	function automatic logic signed [33:0] atan_val(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0: v = 34'sd536870912;
			5'd1: v = 34'sd316933406;
			5'd2: v = 34'sd167458907;
			5'd3: v = 34'sd85004756;
			5'd4: v = 34'sd42667331;
			5'd5: v = 34'sd21354465;
			5'd6: v = 34'sd10679838;
			5'd7: v = 34'sd5340245;
			5'd8: v = 34'sd2670163;
			5'd9: v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction
endpackage

@@ rtl/fcb_cordic.sv @@
module fcb_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [32:0] cos_v,
	output logic signed [32:0] sin_v
);
	import fcb_pkg::*;

	logic signed [33:0] x_q, y_q, a_q;
	logic flip_q, busy_q, done_q;
	logic [ITER_W-1:0] cnt_q;
	logic signed [33:0] a0, af;
	logic fl;

	always_comb begin
		a0 = 34'(signed'(angle));
		af = a0;
		fl = 1'b0;
		if (a0 > 34'sd1073741824) begin
			af = a0 - 34'sd2147483648;
			fl = 1'b1;
		end else if (a0 < -34'sd1073741824) begin
			af = a0 + 34'sd2147483648;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == ITER_W'(CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			a_q <= af;
			flip_q <= fl;
		end else if (busy_q) begin
			if (a_q >= 0) begin
				x_q <= x_q - (y_q >>> cnt_q);
				y_q <= y_q + (x_q >>> cnt_q);
				a_q <= a_q - atan_val(5'(cnt_q));
			end else begin
				x_q <= x_q + (y_q >>> cnt_q);
				y_q <= y_q - (x_q >>> cnt_q);
				a_q <= a_q + atan_val(5'(cnt_q));
			end
		end
	end

	assign done = done_q;
	assign cos_v = 33'(flip_q ? -x_q : x_q);
	assign sin_v = 33'(flip_q ? -y_q : y_q);
endmodule

@@ rtl/fcb_rootdiv.sv @@
module fcb_rootdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  fcb_pkg::rd_req_t  req,
	input  logic [63:0]       rad,
	input  logic [31:0]       den,
	output logic              done,
	output logic [31:0]       res
);
	import fcb_pkg::*;

	logic [63:0] w_q, r_q, t, bit_v;
	logic [31:0] d_q;
	logic [4:0] cnt_q;
	logic mode_q, busy_q, done_q, ge;

	always_comb begin
		bit_v = 64'd1 << {cnt_q, 1'b0};
		if (mode_q)
			t = {32'd0, d_q} << cnt_q;
		else
			t = r_q + bit_v;
		ge = (w_q >= t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mode_q <= req.div_mode;
				cnt_q <= req.div_mode ? 5'(DIV_BITS - 1) : 5'(ROOT_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			w_q <= rad;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (ge)
				w_q <= w_q - t;
			if (mode_q)
				r_q <= {r_q[62:0], ge};
			else
				r_q <= ge ? ((r_q >> 1) + bit_v) : (r_q >> 1);
		end
	end

	assign done = done_q;
	assign res = r_q[31:0];
endmodule

@@ rtl/fly_camera_basis_update_core.sv @@
// Yaw/pitch fly camera. An item (move, turn or place) updates the Q16.16 position
// or the binary-angle yaw and pitch, then the front, right and up Q2.14 vectors are
// recomputed and one result item carries position and vectors. Each item uses two
// CORDIC runs, two 32-step integer square roots and up to six 15-step divisions on
// the shared root/divide unit, and the single shared multiplier for its products.
// A new item is taken only after the previous result item has been delivered.
module fly_camera_basis_update_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic               key_forward,
	input  logic               key_back,
	input  logic               key_left,
	input  logic               key_right,
	input  logic [15:0]        delta_time,
	input  logic signed [15:0] x_change,
	input  logic signed [15:0] y_change,
	input  logic signed [31:0] place_x,
	input  logic signed [31:0] place_y,
	input  logic signed [31:0] place_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z
);
	import fcb_pkg::*;
	`include "assert_macros.svh"

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_OP = 5'd1;
	localparam logic [4:0] ST_MV_VEL = 5'd2;
	localparam logic [4:0] ST_MV_MUL = 5'd3;
	localparam logic [4:0] ST_MV_ADD = 5'd4;
	localparam logic [4:0] ST_TURN_Y = 5'd5;
	localparam logic [4:0] ST_TURN_P = 5'd6;
	localparam logic [4:0] ST_CORD_Y = 5'd7;
	localparam logic [4:0] ST_WAIT_Y = 5'd8;
	localparam logic [4:0] ST_CORD_P = 5'd9;
	localparam logic [4:0] ST_WAIT_P = 5'd10;
	localparam logic [4:0] ST_FRONT_X = 5'd11;
	localparam logic [4:0] ST_FRONT_Z = 5'd12;
	localparam logic [4:0] ST_FRONT_END = 5'd13;
	localparam logic [4:0] ST_CR_MUL = 5'd14;
	localparam logic [4:0] ST_CR_ACC = 5'd15;
	localparam logic [4:0] ST_SQ_MUL = 5'd16;
	localparam logic [4:0] ST_SQ_ACC = 5'd17;
	localparam logic [4:0] ST_ROOT = 5'd18;
	localparam logic [4:0] ST_ROOT_W = 5'd19;
	localparam logic [4:0] ST_DIV = 5'd20;
	localparam logic [4:0] ST_DIV_W = 5'd21;
	localparam logic [4:0] ST_DONE = 5'd22;

	logic [30:0] move_speed_q;
	logic [15:0] turn_speed_q, start_yaw_q;
	logic signed [15:0] wu_q [3];
	logic signed [14:0] start_pitch_q;

	logic signed [31:0] pos_q [3];
	logic [15:0] yaw_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] front_q [3], right_q [3], up_q [3];

	logic [4:0] state_q;
	logic out_valid_q;
	logic [1:0] op_q, key_idx_q, comp_q;
	logic [3:0] keys_q;
	logic [15:0] dt_q;
	logic signed [15:0] xc_q, yc_q;
	logic pass_q;
	logic [2:0] idx_q;
	logic signed [32:0] vel_q, cy_q, sy_q, cp_q, sp_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] cr_q [3];
	logic [63:0] sum_q;
	logic [31:0] len_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	logic cord_start, cord_done;
	logic [31:0] cord_angle;
	logic signed [32:0] cord_cos, cord_sin;
	rd_req_t rd_req;
	logic [63:0] rd_rad;
	logic rd_done;
	logic [31:0] rd_res;

	logic accept, cfg_wr;
	logic [1:0] ck, ci1, ci2;
	logic signed [15:0] cross_a [3], cross_b [3];
	logic [31:0] mag [3];
	logic [1:0] dk;

	function automatic logic [1:0] nxt(input logic [1:0] k);
		logic [1:0] r;
		case (k)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] rnd_clamp(input logic signed [65:0] v);
		logic signed [65:0] c;
		c = v;
		if (c > 66'sd16384)
			c = 66'sd16384;
		else if (c < -66'sd16384)
			c = -66'sd16384;
		return 16'(c);
	endfunction

	assign accept = in_valid && !in_stall;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		case (paddr[4:2])
			REG_MOVE_SPEED: prdata = {1'b0, move_speed_q};
			REG_TURN_SPEED: prdata = {16'd0, turn_speed_q};
			REG_WUP_X: prdata = {16'd0, wu_q[0]};
			REG_WUP_Y: prdata = {16'd0, wu_q[1]};
			REG_WUP_Z: prdata = {16'd0, wu_q[2]};
			REG_START_YAW: prdata = {16'd0, start_yaw_q};
			REG_START_PITCH: prdata = {17'd0, start_pitch_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_speed_q <= 31'd327680;
			turn_speed_q <= 16'd256;
			wu_q[0] <= 16'sd0;
			wu_q[1] <= 16'sd16384;
			wu_q[2] <= 16'sd0;
			start_yaw_q <= 16'd49152;
			start_pitch_q <= 15'sd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MOVE_SPEED: move_speed_q <= pwdata[30:0];
				REG_TURN_SPEED: turn_speed_q <= pwdata[15:0];
				REG_WUP_X: wu_q[0] <= pwdata[15:0];
				REG_WUP_Y: wu_q[1] <= pwdata[15:0];
				REG_WUP_Z: wu_q[2] <= pwdata[15:0];
				REG_START_YAW: start_yaw_q <= pwdata[15:0];
				REG_START_PITCH: start_pitch_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ck = idx_q[2:1];
		ci1 = nxt(ck);
		ci2 = nxt(ci1);
		for (int k = 0; k < 3; k++) begin
			cross_a[k] = pass_q ? right_q[k] : front_q[k];
			cross_b[k] = pass_q ? front_q[k] : wu_q[k];
			mag[k] = cr_q[k][31] ? 32'(-cr_q[k]) : 32'(cr_q[k]);
		end
		dk = comp_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_OP: begin
				if (op_q == OP_MOVE) begin
					mul_a = {2'b00, move_speed_q};
					mul_b = {17'd0, dt_q};
				end else begin
					mul_a = 33'(xc_q);
					mul_b = {17'd0, turn_speed_q};
				end
			end
			ST_MV_MUL: begin
				mul_a = 33'(key_idx_q[1] ? right_q[comp_q] : front_q[comp_q]);
				mul_b = vel_q;
			end
			ST_TURN_Y: begin
				mul_a = 33'(yc_q);
				mul_b = {17'd0, turn_speed_q};
			end
			ST_FRONT_X: begin
				mul_a = cy_q;
				mul_b = cp_q;
			end
			ST_FRONT_Z: begin
				mul_a = sy_q;
				mul_b = cp_q;
			end
			ST_CR_MUL: begin
				mul_a = 33'(idx_q[0] ? cross_a[ci2] : cross_a[ci1]);
				mul_b = 33'(idx_q[0] ? cross_b[ci1] : cross_b[ci2]);
			end
			ST_SQ_MUL: begin
				mul_a = {1'b0, mag[comp_q]};
				mul_b = {1'b0, mag[comp_q]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign cord_start = (state_q == ST_CORD_Y) || (state_q == ST_CORD_P);
	assign cord_angle = (state_q == ST_CORD_Y) ? {yaw_q, 16'd0} : {pitch_q, 16'd0};

	fcb_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .angle(cord_angle),
		.done(cord_done), .cos_v(cord_cos), .sin_v(cord_sin)
	);

	always_comb begin
		rd_req.start = (state_q == ST_ROOT) || ((state_q == ST_DIV) && (len_q != '0));
		rd_req.div_mode = (state_q == ST_DIV);
		rd_rad = (state_q == ST_ROOT) ? sum_q
			: (64'({mag[comp_q], 14'd0}) + 64'(len_q >> 1));
	end

	fcb_rootdiv u_rootdiv (
		.clk(clk), .arst_n(arst_n), .req(rd_req), .rad(rd_rad), .den(len_q),
		.done(rd_done), .res(rd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [33:0] d, p;
		logic signed [25:0] pt;
		logic signed [15:0] q;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= '0;
				right_q[k] <= '0;
				up_q[k] <= '0;
			end
			front_q[0] <= '0;
			front_q[1] <= '0;
			front_q[2] <= -UNIT_ONE;
			yaw_q <= '0;
			pitch_q <= '0;
			key_idx_q <= '0;
			comp_q <= '0;
			idx_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= op;
						keys_q <= {key_right, key_left, key_back, key_forward};
						dt_q <= delta_time;
						xc_q <= x_change;
						yc_q <= y_change;
						if (op == OP_PLACE) begin
							pos_q[0] <= place_x;
							pos_q[1] <= place_y;
							pos_q[2] <= place_z;
							yaw_q <= start_yaw_q;
							pt = 26'(start_pitch_q);
							if (pt > PITCH_LIMIT)
								pt = PITCH_LIMIT;
							else if (pt < -PITCH_LIMIT)
								pt = -PITCH_LIMIT;
							pitch_q <= 16'(pt);
						end
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					if (op_q == OP_MOVE)
						state_q <= ST_MV_VEL;
					else if (op_q == OP_TURN)
						state_q <= ST_TURN_Y;
					else
						state_q <= ST_CORD_Y;
				end
				ST_MV_VEL: begin
					vel_q <= 33'(prod_q >>> 16);
					key_idx_q <= '0;
					comp_q <= '0;
					state_q <= ST_MV_MUL;
				end
				ST_MV_MUL: begin
					if (keys_q[key_idx_q])
						state_q <= ST_MV_ADD;
					else if (key_idx_q == 2'd3)
						state_q <= ST_CORD_Y;
					else
						key_idx_q <= key_idx_q + 1'b1;
				end
				ST_MV_ADD: begin
					d = 34'(prod_q >>> 14);
					if (key_idx_q == 2'd1 || key_idx_q == 2'd2)
						p = 34'(pos_q[dk]) - d;
					else
						p = 34'(pos_q[dk]) + d;
					if (p > 34'sd2147483647)
						p = 34'sd2147483647;
					else if (p < -34'sd2147483648)
						p = -34'sd2147483648;
					pos_q[dk] <= 32'(p);
					if (comp_q == 2'd2) begin
						comp_q <= '0;
						if (key_idx_q == 2'd3) begin
							state_q <= ST_CORD_Y;
						end else begin
							key_idx_q <= key_idx_q + 1'b1;
							state_q <= ST_MV_MUL;
						end
					end else begin
						comp_q <= comp_q + 1'b1;
						state_q <= ST_MV_MUL;
					end
				end
				ST_TURN_Y: begin
					yaw_q <= yaw_q + prod_q[23:8];
					state_q <= ST_TURN_P;
				end
				ST_TURN_P: begin
					pt = 26'(pitch_q) + 26'(prod_q >>> 8);
					if (pt > PITCH_LIMIT)
						pt = PITCH_LIMIT;
					else if (pt < -PITCH_LIMIT)
						pt = -PITCH_LIMIT;
					pitch_q <= 16'(pt);
					state_q <= ST_CORD_Y;
				end
				ST_CORD_Y: state_q <= ST_WAIT_Y;
				ST_WAIT_Y: begin
					if (cord_done) begin
						cy_q <= cord_cos;
						sy_q <= cord_sin;
						state_q <= ST_CORD_P;
					end
				end
				ST_CORD_P: state_q <= ST_WAIT_P;
				ST_WAIT_P: begin
					if (cord_done) begin
						cp_q <= cord_cos;
						sp_q <= cord_sin;
						state_q <= ST_FRONT_X;
					end
				end
				ST_FRONT_X: state_q <= ST_FRONT_Z;
				ST_FRONT_Z: begin
					front_q[0] <= rnd_clamp((prod_q + (66'sd1 <<< 45)) >>> 46);
					front_q[1] <= rnd_clamp((66'(sp_q) + 66'sd32768) >>> 16);
					state_q <= ST_FRONT_END;
				end
				ST_FRONT_END: begin
					front_q[2] <= rnd_clamp((prod_q + (66'sd1 <<< 45)) >>> 46);
					pass_q <= 1'b0;
					idx_q <= '0;
					state_q <= ST_CR_MUL;
				end
				ST_CR_MUL: state_q <= ST_CR_ACC;
				ST_CR_ACC: begin
					if (!idx_q[0])
						acc_q <= prod_q[31:0];
					else
						cr_q[ck] <= acc_q - prod_q[31:0];
					if (idx_q == 3'd5) begin
						comp_q <= '0;
						sum_q <= '0;
						state_q <= ST_SQ_MUL;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_CR_MUL;
					end
				end
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					sum_q <= sum_q + prod_q[63:0];
					if (comp_q == 2'd2) begin
						state_q <= ST_ROOT;
					end else begin
						comp_q <= comp_q + 1'b1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_ROOT: state_q <= ST_ROOT_W;
				ST_ROOT_W: begin
					if (rd_done) begin
						len_q <= rd_res;
						comp_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV, ST_DIV_W: begin
					if (state_q == ST_DIV && len_q != '0) begin
						state_q <= ST_DIV_W;
					end else if (state_q == ST_DIV || rd_done) begin
						q = '0;
						if (len_q != '0)
							q = (rd_res > 32'd16384) ? UNIT_ONE : 16'(rd_res);
						if (cr_q[dk][31])
							q = -q;
						if (pass_q)
							up_q[dk] <= q;
						else
							right_q[dk] <= q;
						if (comp_q == 2'd2) begin
							if (pass_q) begin
								state_q <= ST_DONE;
							end else begin
								pass_q <= 1'b1;
								idx_q <= '0;
								state_q <= ST_CR_MUL;
							end
						end else begin
							comp_q <= comp_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];
	assign front_x = front_q[0];
	assign front_y = front_q[1];
	assign front_z = front_q[2];
	assign right_x = right_q[0];
	assign right_y = right_q[1];
	assign right_z = right_q[2];
	assign up_x = up_q[0];
	assign up_y = up_q[1];
	assign up_z = up_q[2];

	`ASSERT_AT(a_hold_while_result, clk, arst_n, !out_valid_q || in_stall, "item taken while result pending")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE, "sequencer idle after accept")
	`ASSERT_AT(a_pitch_range, clk, arst_n, (pitch_q <= 16'sd16202) && (pitch_q >= -16'sd16202), "pitch out of range")
endmodule

@@ sim/fly_camera_basis_update_core_tb.sv @@
`timescale 1ns / 100ps

module fly_camera_basis_update_core_tb;
	import fcb_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic kf, kb, kl, kr;
		logic [15:0] dt;
		logic signed [15:0] xc, yc;
		logic signed [31:0] px, py, pz;
	} cam_item_t;

	typedef struct packed {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
	} cam_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = '0;
	logic key_forward = 0, key_back = 0, key_left = 0, key_right = 0;
	logic [15:0] delta_time = '0;
	logic signed [15:0] x_change = '0, y_change = '0;
	logic signed [31:0] place_x = '0, place_y = '0, place_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] front_x, front_y, front_z, right_x, right_y, right_z;
	logic signed [15:0] up_x, up_y, up_z;

	fly_camera_basis_update_core dut (.*);

	always #6 clk = ~clk;

	cam_item_t pending_items[$];
	cam_view_t expected_views[$];
	int errors = 0;
	int checked = 0;
	int turns_seen = 0, moves_seen = 0, places_seen = 0;
	bit calm = 0;
	int hold_off = 0;
	int send_gap = 0;
	int recv_gap = 0;

	// Predictor state.
	logic [30:0] p_speed;
	logic [15:0] p_turn;
	logic signed [15:0] p_wup[3];
	logic [15:0] p_syaw;
	logic signed [14:0] p_spitch;
	logic signed [31:0] p_pos[3];
	logic [15:0] p_yaw;
	logic signed [31:0] p_pitch;
	logic signed [31:0] p_front[3], p_right[3], p_up[3];

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint atan_ent(int i);
		longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	task automatic rotate_angle(input logic [31:0] ang, output longint c, output longint s);
		longint a, x, y, nx;
		bit flip;
		a = ang;
		x = 652032874;
		y = 0;
		flip = 0;
		if (a >= 64'sd2147483648) a -= 64'sd4294967296;
		if (a > 1073741824) begin
			a -= 64'sd2147483648;
			flip = 1;
		end else if (a < -1073741824) begin
			a += 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (a >= 0) begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				a -= atan_ent(i);
			end else begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				a += atan_ent(i);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic unit_vector(input longint c[3], output logic signed [31:0] o[3],
			output bit ok);
		longint unsigned mag[3], sum, len, q;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = c[k] < 0 ? -c[k] : c[k];
			sum += mag[k] * mag[k];
		end
		len = root_floor(sum);
		ok = len != 0;
		for (int k = 0; k < 3; k++) begin
			if (!ok) begin
				o[k] = 0;
			end else begin
				q = (mag[k] * 16384 + len / 2) / len;
				if (q > 16384) q = 16384;
				o[k] = c[k] < 0 ? -$signed(q[31:0]) : $signed(q[31:0]);
			end
		end
	endtask

	function automatic longint round_q14(longint v, int s);
		return clip(asr(v + (64'sd1 <<< (s - 1)), s), -16384, 16384);
	endfunction

	task automatic update_basis();
		longint cy, sy, cp, sp, cr[3];
		logic [31:0] pa;
		bit ok;
		pa = {p_pitch[15:0], 16'h0};
		rotate_angle({p_yaw, 16'h0}, cy, sy);
		rotate_angle(pa, cp, sp);
		p_front[0] = 32'(round_q14(cy * cp, 46));
		p_front[1] = 32'(round_q14(sp, 16));
		p_front[2] = 32'(round_q14(sy * cp, 46));
		cr[0] = longint'(p_front[1]) * p_wup[2] - longint'(p_front[2]) * p_wup[1];
		cr[1] = longint'(p_front[2]) * p_wup[0] - longint'(p_front[0]) * p_wup[2];
		cr[2] = longint'(p_front[0]) * p_wup[1] - longint'(p_front[1]) * p_wup[0];
		unit_vector(cr, p_right, ok);
		if (!ok) begin
			for (int k = 0; k < 3; k++) p_up[k] = 0;
		end else begin
			cr[0] = longint'(p_right[1]) * p_front[2] - longint'(p_right[2]) * p_front[1];
			cr[1] = longint'(p_right[2]) * p_front[0] - longint'(p_right[0]) * p_front[2];
			cr[2] = longint'(p_right[0]) * p_front[1] - longint'(p_right[1]) * p_front[0];
			unit_vector(cr, p_up, ok);
		end
	endtask

	task automatic step_position(input logic signed [31:0] v[3], input longint vel,
			input bit neg);
		longint d;
		for (int k = 0; k < 3; k++) begin
			d = asr(longint'(v[k]) * vel, 14);
			p_pos[k] = 32'(clip(longint'(p_pos[k]) + (neg ? -d : d),
				-64'sd2147483648, 64'sd2147483647));
		end
	endtask

	task automatic predict_view(input cam_item_t it);
		longint vel, dx, dy;
		cam_view_t v;
		if (it.op == OP_MOVE) begin
			vel = asr(longint'(p_speed) * it.dt, 16);
			if (it.kf) step_position(p_front, vel, 0);
			if (it.kb) step_position(p_front, vel, 1);
			if (it.kl) step_position(p_right, vel, 1);
			if (it.kr) step_position(p_right, vel, 0);
		end else if (it.op == OP_TURN) begin
			dx = asr(longint'(it.xc) * p_turn, 8);
			dy = asr(longint'(it.yc) * p_turn, 8);
			p_yaw = p_yaw + dx[15:0];
			p_pitch = 32'(clip(longint'(p_pitch) + dy, -PITCH_LIMIT, PITCH_LIMIT));
		end else if (it.op == OP_PLACE) begin
			p_pos[0] = it.px;
			p_pos[1] = it.py;
			p_pos[2] = it.pz;
			p_yaw = p_syaw;
			p_pitch = 32'(clip(longint'(p_spitch), -PITCH_LIMIT, PITCH_LIMIT));
		end
		update_basis();
		v.px = p_pos[0];
		v.py = p_pos[1];
		v.pz = p_pos[2];
		v.fx = 16'(p_front[0]);
		v.fy = 16'(p_front[1]);
		v.fz = 16'(p_front[2]);
		v.rx = 16'(p_right[0]);
		v.ry = 16'(p_right[1]);
		v.rz = 16'(p_right[2]);
		v.ux = 16'(p_up[0]);
		v.uy = 16'(p_up[1]);
		v.uz = 16'(p_up[2]);
		expected_views.push_back(v);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, checked, got, want);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_MOVE_SPEED: p_speed = val[30:0];
			REG_TURN_SPEED: p_turn = val[15:0];
			REG_WUP_X: p_wup[0] = val[15:0];
			REG_WUP_Y: p_wup[1] = val[15:0];
			REG_WUP_Z: p_wup[2] = val[15:0];
			REG_START_YAW: p_syaw = val[15:0];
			REG_START_PITCH: p_spitch = val[14:0];
			default: ;
		endcase
	endtask

	function automatic cam_item_t rand_item(int mode);
		cam_item_t it;
		it.op = (mode == 0) ? 2'($urandom_range(0, 3)) : 2'(mode - 1);
		{it.kf, it.kb, it.kl, it.kr} = 4'($urandom);
		it.dt = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom);
		it.xc = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($signed($urandom_range(0, 800)) - 400);
		it.yc = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($signed($urandom_range(0, 800)) - 400);
		it.px = $urandom;
		it.py = $urandom;
		it.pz = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			it.px = $signed(it.px) >>> 12;
			it.py = $signed(it.py) >>> 12;
			it.pz = $signed(it.pz) >>> 12;
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_views.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_view({op, key_forward, key_back, key_left, key_right, delta_time,
					x_change, y_change, place_x, place_y, place_z});
				case (op)
					OP_MOVE: moves_seen++;
					OP_TURN: turns_seen++;
					OP_PLACE: places_seen++;
					default: ;
				endcase
			end
			if ((!in_valid || !in_stall) && send_gap > 0) begin
				in_valid <= 0;
				send_gap <= send_gap - 1;
			end else if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0) begin
					cam_item_t it;
					it = pending_items.pop_front();
					in_valid <= 1;
					{op, key_forward, key_back, key_left, key_right, delta_time,
						x_change, y_change, place_x, place_y, place_z} <= it;
					if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 7);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					errors++;
					$display("result with no expectation waiting");
				end else begin
					cam_view_t w;
					w = expected_views.pop_front();
					if (pos_x !== w.px) report_mismatch("pos_x", pos_x, w.px);
					if (pos_y !== w.py) report_mismatch("pos_y", pos_y, w.py);
					if (pos_z !== w.pz) report_mismatch("pos_z", pos_z, w.pz);
					if (front_x !== w.fx) report_mismatch("front_x", front_x, w.fx);
					if (front_y !== w.fy) report_mismatch("front_y", front_y, w.fy);
					if (front_z !== w.fz) report_mismatch("front_z", front_z, w.fz);
					if (right_x !== w.rx) report_mismatch("right_x", right_x, w.rx);
					if (right_y !== w.ry) report_mismatch("right_y", right_y, w.ry);
					if (right_z !== w.rz) report_mismatch("right_z", right_z, w.rz);
					if (up_x !== w.ux) report_mismatch("up_x", up_x, w.ux);
					if (up_y !== w.uy) report_mismatch("up_y", up_y, w.uy);
					if (up_z !== w.uz) report_mismatch("up_z", up_z, w.uz);
				end
				checked++;
			end
			if (hold_off > 0) begin
				out_stall <= 1;
				hold_off <= hold_off - 1;
			end else if (recv_gap > 0) begin
				out_stall <= 1;
				recv_gap <= recv_gap - 1;
			end else begin
				out_stall <= 0;
				if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 7);
			end
		end
	end

	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		cam_item_t it;
		p_speed = 31'd327680;
		p_turn = 16'd256;
		p_wup[0] = 16'sd0;
		p_wup[1] = 16'sd16384;
		p_wup[2] = 16'sd0;
		p_syaw = 16'd49152;
		p_spitch = 15'sd0;
		for (int k = 0; k < 3; k++) begin
			p_pos[k] = 0;
			p_right[k] = 0;
			p_up[k] = 0;
			p_front[k] = 0;
		end
		p_front[2] = -16384;
		p_yaw = 0;
		p_pitch = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		it = '0;
		it.op = OP_MOVE;
		{it.kf, it.kb, it.kl, it.kr} = 4'b1111;
		it.dt = 16'hffff;
		pending_items.push_back(it);
		it.op = OP_PLACE;
		it.px = 32'sh7fffff00;
		it.py = 32'sh80000000;
		it.pz = 32'sh7fffffff;
		pending_items.push_back(it);
		it.op = OP_MOVE;
		{it.kf, it.kb, it.kl, it.kr} = 4'b1000;
		pending_items.push_back(it);
		{it.kf, it.kb, it.kl, it.kr} = 4'b0101;
		pending_items.push_back(it);
		it.op = OP_TURN;
		it.xc = 16'sh7fff;
		it.yc = 16'sh7fff;
		pending_items.push_back(it);
		it.xc = 16'sh8000;
		it.yc = 16'sh8000;
		pending_items.push_back(it);
		it.op = OP_SPARE;
		pending_items.push_back(it);
		it.op = OP_TURN;
		it.xc = -1;
		it.yc = 0;
		pending_items.push_back(it);
		wait_drained();

		write_reg(REG_MOVE_SPEED, 32'h7fffffff);
		write_reg(REG_TURN_SPEED, 32'hffff);
		write_reg(REG_WUP_X, 32'd0);
		write_reg(REG_WUP_Y, 32'hffffc000);
		write_reg(REG_WUP_Z, 32'd0);
		write_reg(REG_START_YAW, 32'hffff);
		write_reg(REG_START_PITCH, 32'h3fff);
		for (int i = 0; i < 6; i++) pending_items.push_back(rand_item(i % 3 + 1));
		wait_drained();

		write_reg(REG_START_PITCH, 32'h4000);
		write_reg(REG_START_YAW, 32'd0);
		write_reg(REG_WUP_Y, 32'd0);
		write_reg(REG_WUP_X, 32'h4000);
		write_reg(REG_TURN_SPEED, 32'd0);
		write_reg(REG_MOVE_SPEED, 32'd0);
		it.op = OP_PLACE;
		pending_items.push_back(it);
		it.op = OP_MOVE;
		pending_items.push_back(it);
		wait_drained();
		write_reg(REG_WUP_X, 32'd0);
		it.op = OP_TURN;
		pending_items.push_back(it);
		it.op = OP_PLACE;
		pending_items.push_back(it);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_MOVE_SPEED, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000000));
			write_reg(REG_TURN_SPEED, $urandom_range(0, 2000));
			write_reg(REG_WUP_X, $signed($urandom_range(0, 32768)) - 16384);
			write_reg(REG_WUP_Y, $signed($urandom_range(0, 32768)) - 16384);
			write_reg(REG_WUP_Z, $signed($urandom_range(0, 32768)) - 16384);
			write_reg(REG_START_YAW, $urandom);
			write_reg(REG_START_PITCH, $urandom);
			if (ph == 1) hold_off <= 400;
			for (int i = 0; i < 300; i++) begin
				if (ph == 3 && i == 200) calm = 1;
				pending_items.push_back(rand_item($urandom_range(0, 4) == 0 ? 3 : 0));
				if (i == 150) wait_drained();
			end
			wait_drained();
		end

		$display("covered %0d moves, %0d turns and %0d places over several register settings",
			moves_seen, turns_seen, places_seen);
		$display("checked %0d results with stalls on both sides", checked);
		if (errors == 0 && expected_views.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
